FILE: rtl/vcodec_pkg.sv
// Shared types, result codes and constants of the varint codec.
`default_nettype none

package vcodec_pkg;

   localparam int unsigned GROUP_BITS       = 7;
   localparam int unsigned VALUE_BITS       = 64;
   localparam int unsigned COUNT_BITS       = 4;
   localparam logic [3:0]  MAX_BYTES_NARROW = 4'd5;
   localparam logic [3:0]  MAX_BYTES_WIDE   = 4'd10;

   localparam logic [1:0] KIND_BYTE     = 2'd0;
   localparam logic [1:0] KIND_VALUE    = 2'd1;
   localparam logic [1:0] KIND_TRUNC    = 2'd2;
   localparam logic [1:0] KIND_OVERLONG = 2'd3;

   typedef struct packed {
      logic load;
      logic enc_step;
      logic dec_step;
   } ctrl_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [7:0]            byte_out;
      logic [VALUE_BITS-1:0] value_out;
      logic                  last;
   } result_type;

   // Bit position of the group that belongs to a given byte count.
   function automatic logic [6:0] group_shift(input logic [COUNT_BITS-1:0] seen);
      logic [7:0] pos;
      pos = 8'(seen) * 8'(GROUP_BITS);
      group_shift = pos[6:0] | {pos[7] | pos[6], 6'b0};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/varint_codec_top.sv
// Top level of the unsigned LEB128 varint codec with its handshake and sequencer.
`default_nettype none

// Each word on the req_ side is either an encode request (req_mode 0), which
// yields one to ten encoded bytes on the rsp_ side, or one byte of an encoded
// stream to decode (req_mode 1), which yields a value, a truncation error, an
// overlong error or nothing; rsp_last marks the final word caused by a request.
// The next request may follow a decode byte at once. An encode request is
// loaded into the shift register, which then hands out one seven-bit group
// per cycle while the rsp_ side takes words; req_ready stays low meanwhile.
// A stalled rsp_ side holds the block, and one finished word waits in the
// output register.
module varint_codec_top
   import vcodec_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode,
   input  wire logic                  req_wide,
   input  wire logic [VALUE_BITS-1:0] req_value_in,
   input  wire logic [7:0]            req_byte_in,
   input  wire logic                  req_buffer_end,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_byte_out,
   output logic [VALUE_BITS-1:0]      rsp_value_out,
   output logic                       rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_ENC  = 1'b1;

   logic       state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       slot_free;
   logic       accept;
   ctrl_type   ctrl;
   result_type res;
   logic       res_emit;

   vcodec_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .req_wide       (req_wide),
      .req_value_in   (req_value_in),
      .req_byte_in    (req_byte_in),
      .req_buffer_end (req_buffer_end),
      .res            (res),
      .res_emit       (res_emit)
   );

   always_comb begin
      slot_free     = !rsp_valid_ff || rsp_ready;
      req_ready     = (state_ff == ST_IDLE) && slot_free;
      accept        = req_valid && req_ready;
      ctrl.load     = accept && !req_mode;
      ctrl.dec_step = accept && req_mode;
      ctrl.enc_step = (state_ff == ST_ENC) && slot_free;

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.load) state_in = ST_ENC;
         end
         ST_ENC: begin
            if (ctrl.enc_step && res.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (res_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_emit) rsp_ff <= res;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_ff.kind;
   assign rsp_byte_out  = rsp_ff.byte_out;
   assign rsp_value_out = rsp_ff.value_out;
   assign rsp_last      = rsp_ff.last;

   a_enc_starts: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> (state_ff == ST_ENC && !req_ready))
      else $error("encode request did not start the emitter");

   a_only_bytes_continue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> (rsp_ff.kind == KIND_BYTE))
      else $error("non-final word that is not an encoded byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_emit |-> slot_free)
      else $error("result written over a word not yet taken");

endmodule

`default_nettype wire

FILE: rtl/vcodec_dpath.sv
// Datapath of the varint codec: encode shift register, decode accumulator.
`default_nettype none

module vcodec_dpath
   import vcodec_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_type              ctrl,
   input  wire logic                  req_wide,
   input  wire logic [VALUE_BITS-1:0] req_value_in,
   input  wire logic [7:0]            req_byte_in,
   input  wire logic                  req_buffer_end,
   output result_type                 res,
   output logic                       res_emit
);

   logic [VALUE_BITS-1:0] work_ff, work_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_BITS-1:0] seen_ff, seen_in;

   logic                  enc_more;
   logic [VALUE_BITS-1:0] placed;
   logic [VALUE_BITS-1:0] acc_sum;
   logic [COUNT_BITS-1:0] count;
   logic [COUNT_BITS-1:0] limit;
   logic [6:0]            shift;

   always_comb begin
      enc_more = |work_ff[VALUE_BITS-1:GROUP_BITS];
      shift    = group_shift(seen_ff);
      // A shift amount with its top bit set lies past the word and drops the group.
      placed   = shift[6] ? '0
                 : ({{(VALUE_BITS-GROUP_BITS){1'b0}}, req_byte_in[6:0]} << shift[5:0]);
      acc_sum  = acc_ff | placed;
      count    = seen_ff + 4'd1;
      limit    = req_wide ? MAX_BYTES_WIDE : MAX_BYTES_NARROW;

      res      = '0;
      res_emit = 1'b0;
      work_in  = work_ff;
      acc_in   = acc_ff;
      seen_in  = seen_ff;

      priority if (ctrl.load) begin
         work_in = req_value_in;
      end else if (ctrl.enc_step) begin
         res.kind     = KIND_BYTE;
         res.byte_out = {enc_more, work_ff[6:0]};
         res.last     = !enc_more;
         res_emit     = 1'b1;
         work_in      = work_ff >> GROUP_BITS;
      end else if (ctrl.dec_step) begin
         priority if (!req_byte_in[7]) begin
            res.kind      = KIND_VALUE;
            res.value_out = req_wide ? acc_sum : {32'b0, acc_sum[31:0]};
            res.last      = 1'b1;
            res_emit      = 1'b1;
            acc_in        = '0;
            seen_in       = '0;
         end else if (count >= limit) begin
            res.kind = KIND_OVERLONG;
            res.last = 1'b1;
            res_emit = 1'b1;
            acc_in   = '0;
            seen_in  = '0;
         end else if (req_buffer_end) begin
            res.kind = KIND_TRUNC;
            res.last = 1'b1;
            res_emit = 1'b1;
            acc_in   = '0;
            seen_in  = '0;
         end else begin
            acc_in  = acc_sum;
            seen_in = count;
         end
      end else begin
         res_emit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (reset) begin
         acc_ff  <= '0;
         seen_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         seen_ff <= seen_in;
      end
   end

   a_single_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.load, ctrl.enc_step, ctrl.dec_step}))
      else $error("more than one datapath operation in a cycle");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff < MAX_BYTES_WIDE)
      else $error("decode byte count past the wide limit");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (ctrl.dec_step && res_emit) |=> (seen_ff == '0 && acc_ff == '0))
      else $error("decode state not cleared after a result");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the varint codec: directed and random encode and decode words with handshake idling.
`timescale 1ns / 100ps

module tb_top
   import vcodec_pkg::*;
();

   localparam logic MODE_ENCODE  = 1'b0;
   localparam logic MODE_DECODE  = 1'b1;
   localparam int   RANDOM_ITEMS = 450;
   localparam int   IDLE_LIMIT   = 2000;
   localparam int   HOLD_CYCLES  = 300;
   localparam int   HOLD_AFTER   = 150;
   localparam int   TAIL_CYCLES  = 20;

   typedef struct packed {
      logic                  mode;
      logic                  wide;
      logic [VALUE_BITS-1:0] value_in;
      logic [7:0]            byte_in;
      logic                  buffer_end;
      logic                  drain_first;
   } codec_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = MODE_ENCODE;
   logic                  req_wide = 1'b0;
   logic [VALUE_BITS-1:0] req_value_in = '0;
   logic [7:0]            req_byte_in = '0;
   logic                  req_buffer_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_byte_out;
   logic [VALUE_BITS-1:0] rsp_value_out;
   logic                  rsp_last;

   codec_req_type stim_queue[$];
   result_type    expected_words[$];
   codec_req_type next_req;
   result_type    want_word;

   logic [VALUE_BITS-1:0] dec_acc = '0;
   logic [COUNT_BITS-1:0] dec_count = '0;
   logic                  drain_pending = 1'b0;

   int failures = 0;
   int gap_left = 0;
   int burst_left = 8;
   int hold_left = 0;
   int rsp_count = 0;
   int idle_cycles = 0;
   logic hold_done = 1'b0;
   logic [15:0] cycle_count = '0;

   varint_codec_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_wide       (req_wide),
      .req_value_in   (req_value_in),
      .req_byte_in    (req_byte_in),
      .req_buffer_end (req_buffer_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_value_out  (rsp_value_out),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic push_word(input logic [1:0] kind, input logic [7:0] byte_val,
                            input logic [VALUE_BITS-1:0] value, input logic fin);
      result_type w;
      w.kind      = kind;
      w.byte_out  = byte_val;
      w.value_out = value;
      w.last      = fin;
      expected_words.push_back(w);
   endtask

   task automatic clear_decode();
      dec_acc   = '0;
      dec_count = '0;
   endtask

   // Works out the words that one request causes and updates the decode state.
   task automatic predict_codec(input codec_req_type it);
      logic [VALUE_BITS-1:0] v;
      logic [VALUE_BITS-1:0] acc;
      logic [3:0]            limit;
      logic [3:0]            count;
      int unsigned           shift;
      if (it.mode == MODE_ENCODE) begin
         v = it.value_in;
         while (v[VALUE_BITS-1:GROUP_BITS] != '0) begin
            push_word(KIND_BYTE, {1'b1, v[GROUP_BITS-1:0]}, '0, 1'b0);
            v = v >> GROUP_BITS;
         end
         push_word(KIND_BYTE, v[7:0], '0, 1'b1);
      end else begin
         limit = it.wide ? MAX_BYTES_WIDE : MAX_BYTES_NARROW;
         shift = GROUP_BITS * dec_count;
         count = dec_count + 4'd1;
         acc   = dec_acc;
         if (shift < VALUE_BITS)
            acc = acc | (VALUE_BITS'(it.byte_in[GROUP_BITS-1:0]) << shift);
         if (!it.byte_in[7]) begin
            push_word(KIND_VALUE, '0, it.wide ? acc : {32'b0, acc[31:0]}, 1'b1);
            clear_decode();
         end else if (count >= limit) begin
            push_word(KIND_OVERLONG, '0, '0, 1'b1);
            clear_decode();
         end else if (it.buffer_end) begin
            push_word(KIND_TRUNC, '0, '0, 1'b1);
            clear_decode();
         end else begin
            dec_acc   = acc;
            dec_count = count;
         end
      end
   endtask

   function automatic logic [VALUE_BITS-1:0] rand_value();
      logic [VALUE_BITS-1:0] v;
      v = {$urandom(), $urandom()};
      return v >> $urandom_range(0, VALUE_BITS - 1);
   endfunction

   task automatic add_encode(input logic [VALUE_BITS-1:0] value);
      codec_req_type r;
      r.mode        = MODE_ENCODE;
      r.wide        = 1'($urandom);
      r.value_in    = value;
      r.byte_in     = 8'($urandom);
      r.buffer_end  = 1'($urandom);
      r.drain_first = drain_pending;
      drain_pending = 1'b0;
      stim_queue.push_back(r);
   endtask

   task automatic add_decode(input logic [7:0] byte_val, input logic wide, input logic bend);
      codec_req_type r;
      r.mode        = MODE_DECODE;
      r.wide        = wide;
      r.value_in    = {$urandom(), $urandom()};
      r.byte_in     = byte_val;
      r.buffer_end  = bend;
      r.drain_first = drain_pending;
      drain_pending = 1'b0;
      stim_queue.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [VALUE_BITS-1:0] want,
                              input logic [VALUE_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (stim_queue.size() == 0 ||
                      (stim_queue[0].drain_first && expected_words.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            next_req = stim_queue.pop_front();
            req_valid      <= 1'b1;
            req_mode       <= next_req.mode;
            req_wide       <= next_req.wide;
            req_value_in   <= next_req.value_in;
            req_byte_in    <= next_req.byte_in;
            req_buffer_end <= next_req.buffer_end;
            predict_codec(next_req);
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 16'd1;
      if (rsp_valid && rsp_ready)
         rsp_count = rsp_count + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         case (cycle_count[9:7])
            3'd2:    rsp_ready <= 1'($urandom);
            3'd3:    rsp_ready <= ($urandom_range(0, 7) != 0);
            3'd4:    rsp_ready <= (cycle_count[1:0] == 2'd0);
            3'd5:    rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: word with nothing expected, kind %0d byte %0h value %0h last %0b",
                     $time, rsp_kind, rsp_byte_out, rsp_value_out, rsp_last);
            failures++;
         end else begin
            want_word = expected_words.pop_front();
            check_field("kind", VALUE_BITS'(want_word.kind), VALUE_BITS'(rsp_kind));
            check_field("byte_out", VALUE_BITS'(want_word.byte_out),
                        VALUE_BITS'(rsp_byte_out));
            check_field("value_out", want_word.value_out, rsp_value_out);
            check_field("last", VALUE_BITS'(want_word.last), VALUE_BITS'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int   start;
      int   len;
      int   sel;
      logic wide;
      logic mid_pause;
      logic [3:0] limit;

      add_encode(64'd0);
      add_encode(64'd127);
      add_encode(64'd128);
      add_encode('1);
      add_encode(64'hFFFF_FFFF);
      add_decode(8'h00, 1'b0, 1'b1);
      add_decode(8'h7F, 1'b1, 1'b0);
      for (int i = 0; i < 9; i++)
         add_decode(8'hFF, 1'b1, 1'b0);
      add_decode(8'h01, 1'b1, 1'b1);
      for (int i = 0; i < 4; i++)
         add_decode(8'hFF, 1'b0, 1'b0);
      add_encode(64'd300);
      add_decode(8'hFF, 1'b0, 1'b0);
      add_decode(8'h80, 1'b0, 1'b1);

      drain_pending = 1'b1;
      mid_pause = 1'b0;
      start = stim_queue.size();
      while (stim_queue.size() < start + RANDOM_ITEMS) begin
         if (!mid_pause && stim_queue.size() >= start + RANDOM_ITEMS / 2) begin
            drain_pending = 1'b1;
            mid_pause = 1'b1;
         end
         sel   = $urandom_range(0, 99);
         wide  = 1'($urandom);
         limit = wide ? MAX_BYTES_WIDE : MAX_BYTES_NARROW;
         if (sel < 30) begin
            add_encode(rand_value());
         end else if (sel < 75) begin
            len = $urandom_range(1, limit);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 19) == 0)
                  add_encode(rand_value());
               if ($urandom_range(0, 19) == 0)
                  wide = ~wide;
               add_decode({i != len - 1, 7'($urandom)}, wide,
                          (i == len - 1) ? 1'($urandom) : 1'b0);
            end
         end else if (sel < 85) begin
            len = $urandom_range(1, limit - 1);
            for (int i = 0; i < len; i++)
               add_decode({1'b1, 7'($urandom)}, wide, i == len - 1);
         end else if (sel < 92) begin
            for (int i = 0; i < limit; i++)
               add_decode({1'b1, 7'($urandom)}, wide, 1'b0);
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
               add_decode(8'($urandom), 1'($urandom), 1'($urandom));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (stim_queue.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
